// ----- hdl/fca_pkg.sv -----
package fca_pkg;

  localparam int NUM_BLOCKS  = 512;
  localparam int BLOCK_BYTES = 32;
  localparam int DIR_ENTRIES = 128;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_DIR_FULL  = 3'd3;
  localparam logic [2:0] ST_BEYOND    = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] file_key;
    logic [14:0] byte_length;
    logic [8:0]  block_index;
  } fca_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] block_number;
    logic [9:0] block_count;
    logic [9:0] free_blocks;
  } fca_rsp_t;

endpackage

// ----- hdl/fat_chain_allocator_core.sv -----
// fat_chain_allocator_core: FAT-style block allocator with a small directory
// of file keys. Requests enter a two-entry queue and the back end runs one
// request at a time; a result waits on the result ports until pop. After
// reset a clearing pass marks every block free before the first request is
// taken (full rises once two requests wait). A rejected insert (empty, no
// space, directory full) or an unused code goes straight to its result. An
// insert scans for free blocks from block 0, reading one link entry a cycle.
// Remove and lookup first search the directory one entry at a time. Remove
// then frees the chain block by block and swaps the last directory entry
// into the freed slot; lookup follows the chain to the block asked for. The
// next request is taken in the cycle after pop.
module fat_chain_allocator_core import fca_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fca_req_t req,
  input  logic     push,
  output logic     full,
  output fca_rsp_t rsp,
  output logic     empty,
  input  logic     pop
);

  fca_req_t    q_req;
  logic [14:0] q_need;
  logic        q_valid, q_take, rsp_valid;

  // Front: accept and size each request.
  fca_front u_front (
    .clk, .rst, .req, .push, .full,
    .q_req, .q_need, .q_valid, .q_take);

  // Back: carry out the request against link and directory memories.
  fca_back u_back (
    .clk, .rst, .q_req, .q_need, .q_valid, .q_take,
    .rsp, .rsp_valid, .rsp_take(pop));

  assign empty = !rsp_valid;

endmodule

// ----- hdl/fca_ram.sv -----
module fca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fca_front.sv -----
module fca_front import fca_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fca_req_t req,
  input  logic     push,
  output logic     full,
  output fca_req_t q_req,
  output logic [14:0] q_need,
  output logic     q_valid,
  input  logic     q_take
);

  // Two-entry queue; blocks needed computed on entry.
  fca_req_t    req_buf [2];
  logic [14:0] need_buf [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic [15:0] len_sum;
  logic [14:0] need;

  // Round up to whole blocks; the block size is a power of two.
  assign len_sum = {1'b0, req.byte_length} + 16'(BLOCK_BYTES - 1);
  assign need    = 15'(len_sum >> $clog2(BLOCK_BYTES));
  assign full    = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign q_req   = req_buf[rd_ptr];
  assign q_need  = need_buf[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        req_buf[wr_ptr]  <= req;
        need_buf[wr_ptr] <= need;
        wr_ptr <= !wr_ptr;
      end
      if (q_take && q_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push && !full) - 2'(q_take && q_valid);
    end
  end

endmodule

// ----- hdl/fca_back.sv -----
module fca_back import fca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fca_req_t    q_req,
  input  logic [14:0] q_need,
  input  logic        q_valid,
  output logic        q_take,
  output fca_rsp_t    rsp,
  output logic        rsp_valid,
  input  logic        rsp_take
);

  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int DW = $clog2(DIR_ENTRIES);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int UW = $clog2(DIR_ENTRIES + 1);

  // Link entry: {valid, end, next}. Not valid means free.
  localparam logic [BW+1:0] LK_FREE = {(BW + 2){1'b0}};
  localparam logic [BW+1:0] LK_END  = {2'b11, {BW{1'b0}}};
  localparam logic [1:0]    LK_LINK = 2'b10;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SCAN = 4'd2,
                         S_TAIL = 4'd3, S_SRCH = 4'd4, S_SRCHW = 4'd5,
                         S_WALK = 4'd6, S_WALKW = 4'd7, S_MVRD = 4'd8,
                         S_MVWR = 4'd9, S_DONE = 4'd10;

  logic [3:0]    state;
  logic          lk_we;
  logic [BW-1:0] lk_waddr, lk_raddr;
  logic [BW+1:0] lk_wdata, lk_rdata;
  logic          lk_is_free;
  logic          dk_we;
  logic [DW-1:0] dk_waddr, dk_raddr;
  logic [31:0]   dk_wdata, dk_rdata;
  logic [BW-1:0] ds_wdata, ds_rdata;

  logic [BW-1:0] clr;
  logic [UW-1:0] used;
  logic [CW-1:0] free_cnt;
  logic [CW:0]   free_sum;
  logic [BW-1:0] cur, prev, first;
  logic [BW:0]   scan_addr;
  logic [BW-1:0] chk_addr;
  logic          chk_vld;
  logic [CW-1:0] cnt;
  logic [CW-1:0] need;
  logic [UW-1:0] slot;
  logic [8:0]    steps;
  logic [1:0]    op;
  logic [31:0]   key;
  logic [8:0]    idx;
  logic [2:0]    rsp_status;
  logic [8:0]    rsp_block;
  logic [9:0]    rsp_count;

  fca_ram #(.WIDTH(BW + 2), .DEPTH(NUM_BLOCKS)) u_link (
    .clk, .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata));
  fca_ram #(.WIDTH(32), .DEPTH(DIR_ENTRIES)) u_keys (
    .clk, .we(dk_we), .waddr(dk_waddr), .wdata(dk_wdata),
    .raddr(dk_raddr), .rdata(dk_rdata));
  fca_ram #(.WIDTH(BW), .DEPTH(DIR_ENTRIES)) u_starts (
    .clk, .we(dk_we), .waddr(dk_waddr), .wdata(ds_wdata),
    .raddr(dk_raddr), .rdata(ds_rdata));

  assign q_take     = state == S_IDLE && q_valid;
  assign rsp_valid  = state == S_DONE;
  assign lk_is_free = !lk_rdata[BW+1];
  assign free_sum   = {1'b0, free_cnt} + {1'b0, cnt};
  assign rsp        = {rsp_status, rsp_block, rsp_count, free_cnt};

  // Memory ports follow the state directly.
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = cur;
    lk_wdata = LK_FREE;
    lk_raddr = cur;
    dk_we    = 1'b0;
    dk_waddr = slot[DW-1:0];
    dk_wdata = dk_rdata;
    ds_wdata = ds_rdata;
    dk_raddr = slot[DW-1:0];
    case (state)
      S_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr;
      end
      S_SCAN: begin
        lk_raddr = scan_addr[BW-1:0];
        // link the previous block to the free one just found
        if (chk_vld && lk_is_free && cnt != '0) begin
          lk_we    = 1'b1;
          lk_waddr = prev;
          lk_wdata = {LK_LINK, chk_addr};
        end
      end
      S_TAIL: begin
        lk_we    = cnt != '0;
        lk_waddr = prev;
        lk_wdata = LK_END;
        dk_we    = cnt != '0;
        dk_waddr = used[DW-1:0];
        dk_wdata = key;
        ds_wdata = first;
      end
      S_WALKW: begin
        lk_we = op == REQ_REMOVE && !lk_is_free;
      end
      S_MVRD: begin
        dk_raddr = DW'(used - 1'b1);
      end
      S_MVWR: begin
        dk_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      used     <= '0;
      free_cnt <= CW'(NUM_BLOCKS);
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == BW'(NUM_BLOCKS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          op <= q_req.req_type; key <= q_req.file_key; idx <= q_req.block_index;
          rsp_status <= ST_OK; rsp_block <= '0; rsp_count <= '0;
          cnt <= '0; slot <= '0; steps <= '0;
          case (q_req.req_type)
            REQ_INSERT: begin
              if (q_need == '0) begin
                rsp_status <= ST_EMPTY; state <= S_DONE;
              end else if (q_need > 15'(free_cnt)) begin
                rsp_status <= ST_NO_SPACE; state <= S_DONE;
              end else if (used == UW'(DIR_ENTRIES)) begin
                rsp_status <= ST_DIR_FULL; state <= S_DONE;
              end else begin
                need <= q_need[CW-1:0];
                scan_addr <= '0; chk_vld <= 1'b0;
                state <= S_SCAN;
              end
            end
            REQ_REMOVE, REQ_LOOKUP: state <= S_SRCH;
            default: state <= S_DONE;
          endcase
        end
        S_SCAN: begin
          // issue one read a cycle; check the entry read the cycle before
          scan_addr <= scan_addr + 1'b1;
          chk_addr  <= scan_addr[BW-1:0];
          chk_vld   <= scan_addr < (BW+1)'(NUM_BLOCKS);
          if (chk_vld) begin
            if (lk_is_free) begin
              cnt  <= cnt + 1'b1;
              prev <= chk_addr;
              if (cnt == '0) first <= chk_addr;
            end
            if ((lk_is_free && cnt + 1'b1 == need) ||
                chk_addr == BW'(NUM_BLOCKS - 1)) state <= S_TAIL;
          end
        end
        S_TAIL: begin
          if (cnt == '0) begin
            rsp_status <= ST_NO_SPACE;
          end else begin
            used      <= used + 1'b1;
            free_cnt  <= free_cnt - cnt;
            rsp_block <= first;
            rsp_count <= cnt;
          end
          state <= S_DONE;
        end
        S_SRCH: begin
          if (slot == used) begin
            rsp_status <= ST_NOT_FOUND; state <= S_DONE;
          end else state <= S_SRCHW;
        end
        S_SRCHW: begin
          if (dk_rdata == key) begin
            cur <= ds_rdata; state <= S_WALK;
          end else begin
            slot <= slot + 1'b1; state <= S_SRCH;
          end
        end
        S_WALK: begin
          if (op == REQ_LOOKUP && steps == idx) begin
            rsp_block <= cur; state <= S_DONE;
          end else state <= S_WALKW;
        end
        S_WALKW: begin
          // lk_rdata is the link entry of cur
          if (op == REQ_LOOKUP) begin
            if (lk_is_free || lk_rdata[BW]) begin
              rsp_status <= ST_BEYOND; state <= S_DONE;
            end else begin
              cur <= lk_rdata[BW-1:0]; steps <= steps + 1'b1; state <= S_WALK;
            end
          end else if (lk_is_free) begin
            state <= S_MVRD;
          end else begin
            cnt <= cnt + 1'b1;
            if (lk_rdata[BW] || cnt + 1'b1 == CW'(NUM_BLOCKS)) begin
              state <= S_MVRD;
            end else begin
              cur <= lk_rdata[BW-1:0]; state <= S_WALK;
            end
          end
        end
        // swap the last entry into the freed slot
        S_MVRD: state <= S_MVWR;
        S_MVWR: begin
          used      <= used - 1'b1;
          free_cnt  <= (free_sum > (CW+1)'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                         : free_sum[CW-1:0];
          rsp_count <= cnt;
          state     <= S_DONE;
        end
        S_DONE: if (rsp_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fca_pkg::*;

  localparam int NBLK       = 512;
  localparam int BLK_BYTES  = 32;
  localparam int NDIR       = 128;
  localparam int LINK_FREE  = -3;
  localparam int LINK_END   = -1;
  localparam int CYCLE_CAP  = 6000000;
  localparam int DRAIN_WAIT = 4000;

  // Request type outside the decoded set; the block must ignore it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  fca_req_t req = '0;
  logic     push = 1'b0;
  logic     full;
  fca_rsp_t rsp;
  logic     empty;
  logic     pop = 1'b0;

  fat_chain_allocator_core dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .push  (push),
    .full  (full),
    .rsp   (rsp),
    .empty (empty),
    .pop   (pop)
  );

  always #10 clk = ~clk;

  // Shadow copy of the allocator state.
  int          chain_link [NBLK];
  logic [31:0] dir_key    [NDIR];
  int          dir_start  [NDIR];
  int          dir_count;
  int          free_left;

  fca_req_t pending_reqs [$];
  fca_rsp_t expected_rsps [$];

  int  errors = 0;
  int  cycles = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_status [8];
  bit  no_idle = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, want %0d (transaction %0d)",
             $time, what, got, want, n_checked);
  endtask

  function automatic bit is_block(input int b);
    return b >= 0 && b < NBLK;
  endfunction

  function automatic int first_free_from(input int start);
    for (int b = start; b < NBLK; b++)
      if (chain_link[b] == LINK_FREE) return b;
    return NBLK;
  endfunction

  function automatic int find_file(input logic [31:0] key);
    for (int i = 0; i < dir_count; i++)
      if (dir_key[i] == key) return i;
    return NDIR;
  endfunction

  // Apply one transaction to the shadow state and return the response it owes.
  function automatic fca_rsp_t allocate_and_predict(input fca_req_t r);
    fca_rsp_t o;
    int need, cur, nxt, k, slot, n;
    o = '0;
    o.status = ST_OK;
    case (r.req_type)
      REQ_INSERT: begin
        need = (int'(r.byte_length) + BLK_BYTES - 1) / BLK_BYTES;
        if (r.byte_length == 0) o.status = ST_EMPTY;
        else if (need > free_left) o.status = ST_NO_SPACE;
        else if (dir_count >= NDIR) o.status = ST_DIR_FULL;
        else begin
          cur = first_free_from(0);
          o.block_number = cur[8:0];
          chain_link[cur] = LINK_END;
          k = 1;
          while (k < need) begin
            nxt = first_free_from(cur);
            if (!is_block(nxt)) break;
            chain_link[cur] = nxt;
            chain_link[nxt] = LINK_END;
            cur = nxt;
            k++;
          end
          free_left -= k;
          dir_key[dir_count] = r.file_key;
          dir_start[dir_count] = int'(o.block_number);
          dir_count++;
          o.block_count = k[9:0];
        end
      end
      REQ_REMOVE: begin
        slot = find_file(r.file_key);
        if (slot == NDIR) o.status = ST_NOT_FOUND;
        else begin
          cur = dir_start[slot];
          n = 0;
          while (is_block(cur) && n < NBLK) begin
            nxt = chain_link[cur];
            if (nxt == LINK_FREE) break;
            chain_link[cur] = LINK_FREE;
            n++;
            cur = nxt;
          end
          free_left += n;
          if (free_left > NBLK) free_left = NBLK;
          dir_key[slot] = dir_key[dir_count - 1];
          dir_start[slot] = dir_start[dir_count - 1];
          dir_count--;
          o.block_count = n[9:0];
        end
      end
      REQ_LOOKUP: begin
        slot = find_file(r.file_key);
        if (slot == NDIR) o.status = ST_NOT_FOUND;
        else begin
          cur = dir_start[slot];
          for (int j = 0; j < int'(r.block_index) && o.status == ST_OK; j++) begin
            if (!is_block(cur)) o.status = ST_BEYOND;
            else cur = chain_link[cur];
          end
          if (o.status == ST_OK && !is_block(cur)) o.status = ST_BEYOND;
          if (o.status == ST_OK) o.block_number = cur[8:0];
        end
      end
      default: ;
    endcase
    o.free_blocks = free_left[9:0];
    return o;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // Driver: account for the accepted transaction at the rising edge, change
  // the inputs at the falling edge.
  int       send_gap = 0;
  logic     push_nxt = 1'b0;
  fca_req_t req_nxt = '0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst) begin
      if (push && !full) begin
        expected_rsps.push_back(allocate_and_predict(req));
        void'(pending_reqs.pop_front());
        n_sent++;
        send_gap = pick_gap();
        push_nxt = 1'b0;
      end
      // hold push high until the transaction is taken
      if (!push_nxt) begin
        if (send_gap > 0) send_gap--;
        else if (pending_reqs.size() > 0) begin
          push_nxt = 1'b1;
          req_nxt = pending_reqs[0];
        end
      end
    end
  end

  always @(negedge clk) begin
    push <= push_nxt;
    req <= req_nxt;
  end

  // Monitor: compare each popped response with the oldest prediction.
  int       pop_gap = 0;
  logic     pop_nxt = 1'b0;
  fca_rsp_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("[%0t] response with nothing expected", $time);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status != want.status)
            report_mismatch("status", int'(rsp.status), int'(want.status));
          if (rsp.block_number != want.block_number)
            report_mismatch("block_number", int'(rsp.block_number),
                            int'(want.block_number));
          if (rsp.block_count != want.block_count)
            report_mismatch("block_count", int'(rsp.block_count),
                            int'(want.block_count));
          if (rsp.free_blocks != want.free_blocks)
            report_mismatch("free_blocks", int'(rsp.free_blocks),
                            int'(want.free_blocks));
          n_status[want.status]++;
        end
        n_checked++;
        pop_gap = pick_gap();
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop_nxt = 1'b0;
      end else pop_nxt = 1'b1;
    end
  end

  always @(negedge clk) pop <= pop_nxt;

  // Stimulus generation
  logic [31:0] live_keys [$];

  function automatic fca_req_t mk(input logic [1:0] t, input logic [31:0] k,
                                  input int len, input int idx);
    fca_req_t r;
    r.req_type = t;
    r.file_key = k;
    r.byte_length = len[14:0];
    r.block_index = idx[8:0];
    return r;
  endfunction

  function automatic logic [31:0] some_key();
    if (live_keys.size() > 0 && $urandom_range(0, 9) < 8)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return $urandom();
  endfunction

  function automatic int some_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 70) return $urandom_range(1, 96);
    if (r < 95) return $urandom_range(97, 2048);
    return $urandom_range(2049, 16384);
  endfunction

  task automatic add_random(input int count, input int insert_pct);
    int r;
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        k = (live_keys.size() > 0 && $urandom_range(0, 19) == 0) ? some_key() : $urandom();
        pending_reqs.push_back(mk(REQ_INSERT, k, some_length(), 0));
        live_keys.push_back(k);
      end else if (r < insert_pct + (100 - insert_pct) / 2) begin
        k = some_key();
        pending_reqs.push_back(mk(REQ_REMOVE, k, $urandom_range(0, 16384), 0));
        foreach (live_keys[j])
          if (live_keys[j] == k) begin
            live_keys.delete(j);
            break;
          end
      end else if (r < 96) begin
        pending_reqs.push_back(mk(REQ_LOOKUP, some_key(), $urandom_range(0, 16384),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                              : $urandom_range(0, 8)));
      end else
        pending_reqs.push_back(mk(REQ_UNUSED, $urandom(), $urandom_range(0, 16384),
                                  $urandom_range(0, 511)));
    end
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || push)
      @(posedge clk);
  endtask

  initial begin
    for (int b = 0; b < NBLK; b++) chain_link[b] = LINK_FREE;
    dir_count = 0;
    free_left = NBLK;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: whole disk in one file, empty file, no space, edges of lookup.
    pending_reqs.push_back(mk(REQ_LOOKUP, 32'h0, 0, 0));
    pending_reqs.push_back(mk(REQ_REMOVE, 32'hFFFF_FFFF, 0, 0));
    pending_reqs.push_back(mk(REQ_INSERT, 32'hFFFF_FFFF, 16384, 0));
    pending_reqs.push_back(mk(REQ_INSERT, 32'h1, 1, 0));
    pending_reqs.push_back(mk(REQ_INSERT, 32'h2, 0, 0));
    pending_reqs.push_back(mk(REQ_LOOKUP, 32'hFFFF_FFFF, 0, 511));
    pending_reqs.push_back(mk(REQ_LOOKUP, 32'hFFFF_FFFF, 0, 0));
    pending_reqs.push_back(mk(REQ_UNUSED, 32'hFFFF_FFFF, 16384, 511));
    pending_reqs.push_back(mk(REQ_REMOVE, 32'hFFFF_FFFF, 0, 0));
    pending_reqs.push_back(mk(REQ_INSERT, 32'hA, 33, 0));
    pending_reqs.push_back(mk(REQ_INSERT, 32'hB, 32, 0));
    pending_reqs.push_back(mk(REQ_INSERT, 32'hA, 64, 0));
    pending_reqs.push_back(mk(REQ_LOOKUP, 32'hA, 0, 1));
    pending_reqs.push_back(mk(REQ_LOOKUP, 32'hA, 0, 2));
    pending_reqs.push_back(mk(REQ_REMOVE, 32'hB, 0, 0));
    pending_reqs.push_back(mk(REQ_INSERT, 32'hC, 96, 0));
    pending_reqs.push_back(mk(REQ_LOOKUP, 32'hC, 0, 2));
    pending_reqs.push_back(mk(REQ_REMOVE, 32'hA, 0, 0));
    pending_reqs.push_back(mk(REQ_LOOKUP, 32'hA, 0, 0));
    pending_reqs.push_back(mk(REQ_REMOVE, 32'hA, 0, 0));
    pending_reqs.push_back(mk(REQ_REMOVE, 32'hC, 0, 0));
    pending_reqs.push_back(mk(REQ_REMOVE, 32'hC, 0, 0));

    // hold the sender until every response is back
    wait_quiet();
    add_random(300, 45);

    // Fill the directory with small files, then hit it when full.
    wait_quiet();
    no_idle = 1'b1;
    for (int i = 0; i < 135; i++) begin
      pending_reqs.push_back(mk(REQ_INSERT, 32'h8000_0000 + i, $urandom_range(1, 32), 0));
    end
    wait_quiet();
    no_idle = 1'b0;
    for (int i = 0; i < 135; i++)
      pending_reqs.push_back(mk(i % 3 == 0 ? REQ_LOOKUP : REQ_REMOVE, 32'h8000_0000 + i,
                                0, $urandom_range(0, 1)));
    add_random(200, 60);
    no_idle = 1'b1;
    add_random(100, 45);
    wait_quiet();
    no_idle = 1'b0;
    add_random(80, 45);

    wait_quiet();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d requests, checked %0d responses", n_sent, n_checked);
    $display("status mix: ok %0d, not found %0d, no space %0d, dir full %0d, beyond %0d, empty %0d",
             n_status[ST_OK], n_status[ST_NOT_FOUND], n_status[ST_NO_SPACE],
             n_status[ST_DIR_FULL], n_status[ST_BEYOND], n_status[ST_EMPTY]);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/fca_pkg.sv
hdl/fca_ram.sv
hdl/fca_front.sv
hdl/fca_back.sv
hdl/fat_chain_allocator_core.sv
tb/tb.sv
